// File: rtl/core/crcpf_pkg.sv
package crcpf_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

	localparam logic [7:0] START_BYTE_RESET = 8'd126;
	localparam int QUEUE_DEPTH = 4;

	// item kinds on s_axis_tuser
	localparam logic MODE_HEADER  = 1'b0;
	localparam logic MODE_PAYLOAD = 1'b1;

	// register map
	localparam int PADDR_W = 3;
	localparam logic [0:0] REG_START_BYTE = 1'b0;

	// index of the final byte of each command's byte sequence
	localparam logic [2:0] LAST_HDR_OPEN  = 3'd2;
	localparam logic [2:0] LAST_HDR_EMPTY = 3'd6;
	localparam logic [2:0] LAST_DATA_MID  = 3'd0;
	localparam logic [2:0] LAST_DATA_END  = 3'd4;

	typedef struct packed {
		logic [6:0][7:0] seq;
		logic [2:0]      last_idx;
		logic            has_crc;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic       open;
		logic [7:0] left;
	} front_status_t;

endpackage

// File: rtl/core/crcpf_front.sv
module crcpf_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    mode,
	input  logic [7:0]              payload_length,
	input  logic [7:0]              packet_type,
	input  logic [7:0]              payload_byte,
	input  logic [7:0]              start_byte,
	input  crcpf_pkg::q_status_t    q_status,
	output logic                    push,
	output crcpf_pkg::cmd_t         cmd,
	output crcpf_pkg::front_status_t status
);

	logic [31:0] crc_q;
	logic [7:0]  left_q;
	logic        open_q;

	logic        accept;
	logic [31:0] crc_next;
	logic [31:0] crc_fin;
	logic [7:0]  left_dec;
	logic        last_byte;

	function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ crcpf_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	assign in_ready  = !q_status.full;
	assign accept    = in_valid && in_ready;
	assign crc_next  = crc_fold(crc_q, payload_byte);
	assign crc_fin   = crc_next ^ crcpf_pkg::CRC_ONES;
	assign left_dec  = left_q - 8'd1;
	assign last_byte = (left_dec == 8'd0);

	assign push = accept && ((mode == crcpf_pkg::MODE_HEADER) || open_q);

	always_comb begin
		cmd = '0;
		unique case (mode)
			crcpf_pkg::MODE_HEADER: begin
				// empty payload: CRC of no data is all zero bytes
				cmd.seq[0]   = start_byte;
				cmd.seq[1]   = payload_length;
				cmd.seq[2]   = packet_type;
				cmd.has_crc  = (payload_length == 8'd0);
				cmd.last_idx = cmd.has_crc ? crcpf_pkg::LAST_HDR_EMPTY
					: crcpf_pkg::LAST_HDR_OPEN;
			end
			crcpf_pkg::MODE_PAYLOAD: begin
				cmd.seq[0]   = payload_byte;
				cmd.seq[1]   = crc_fin[7:0];
				cmd.seq[2]   = crc_fin[15:8];
				cmd.seq[3]   = crc_fin[23:16];
				cmd.seq[4]   = crc_fin[31:24];
				cmd.has_crc  = last_byte;
				cmd.last_idx = last_byte ? crcpf_pkg::LAST_DATA_END
					: crcpf_pkg::LAST_DATA_MID;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= crcpf_pkg::CRC_ONES;
			left_q <= 8'd0;
			open_q <= 1'b0;
		end else if (push) begin
			if (mode == crcpf_pkg::MODE_HEADER) begin
				crc_q  <= crcpf_pkg::CRC_ONES;
				left_q <= payload_length;
				open_q <= (payload_length != 8'd0);
			end else begin
				crc_q  <= crc_next;
				left_q <= left_dec;
				open_q <= !last_byte;
			end
		end
	end

	assign status.open = open_q;
	assign status.left = left_q;

endmodule

// File: rtl/core/crcpf_queue.sv
module crcpf_queue #(
	parameter int DEPTH = crcpf_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  crcpf_pkg::cmd_t      wr_cmd,
	input  logic                 pop,
	output crcpf_pkg::cmd_t      head,
	output crcpf_pkg::q_status_t status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	crcpf_pkg::cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/crcpf_back.sv
module crcpf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crcpf_pkg::cmd_t      head,
	input  crcpf_pkg::q_status_t q_status,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 frame_end
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       end_q;
	logic [2:0] step_q;

	logic adv;
	logic fire;
	logic at_last;

	// output slot frees when empty or when its byte is taken this cycle
	assign adv     = !valid_q || out_ready;
	assign fire    = adv && !q_status.empty;
	assign at_last = (step_q == head.last_idx);
	assign pop     = fire && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= 3'd0;
		end else if (fire) begin
			valid_q <= 1'b1;
			step_q  <= at_last ? 3'd0 : step_q + 3'd1;
		end else if (adv) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= head.seq[step_q];
			end_q  <= head.has_crc && at_last;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign frame_end = end_q;

endmodule

// File: rtl/core/crc32_packet_framer.sv
// Packet framer with CRC-32. A header request (tuser = 0) produces the start byte, the
// length and the type, and restarts the CRC; each payload request (tuser = 1) produces its
// byte and folds it into the CRC (reflected 0xEDB88320, init and final xor all ones). After
// the last payload byte, or right after a zero-length header, the four CRC bytes follow low
// byte first, the final one with tlast. Payload with no open packet is dropped; a header
// abandons an open packet. The front end classifies requests and updates the CRC register,
// then posts a byte sequence into a QDepth-entry queue; the back end emits one byte per cycle
// from the queue head while m_axis_tready allows. A payload byte without CRC yields one output
// byte, so payload streams at one byte per clock unless the sink stalls; a header yields 3 bytes
// (7 when empty) and a closing payload byte 5, during which input is taken until the queue fills.
module crc32_packet_framer #(
	parameter int QDepth = crcpf_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crcpf_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [7:0] payload_length, [15:8] packet_type, [23:16] payload_byte
	input  logic [23:0]                   s_axis_tdata,
	// [0] mode
	input  logic                          s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [7:0] out_byte
	output logic [7:0]                    m_axis_tdata,
	output logic                          m_axis_tlast
);

	logic [7:0] start_q;
	logic       reg_sel;

	logic                    q_push;
	logic                    q_pop;
	crcpf_pkg::cmd_t         q_wr_cmd;
	crcpf_pkg::cmd_t         q_head;
	crcpf_pkg::q_status_t    q_status;
	crcpf_pkg::front_status_t f_status;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[crcpf_pkg::PADDR_W-1] == crcpf_pkg::REG_START_BYTE);
	assign prdata  = reg_sel ? {24'd0, start_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= crcpf_pkg::START_BYTE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			start_q <= pwdata[7:0];
		end
	end

	crcpf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.mode           (s_axis_tuser),
		.payload_length (s_axis_tdata[7:0]),
		.packet_type    (s_axis_tdata[15:8]),
		.payload_byte   (s_axis_tdata[23:16]),
		.start_byte     (start_q),
		.q_status       (q_status),
		.push           (q_push),
		.cmd            (q_wr_cmd),
		.status         (f_status)
	);

	crcpf_queue #(
		.DEPTH (QDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (q_wr_cmd),
		.pop    (q_pop),
		.head   (q_head),
		.status (q_status)
	);

	crcpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_status  (q_status),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.frame_end (m_axis_tlast)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !q_push)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.empty |-> !q_pop)
		else $error("pop from empty queue");

	a_open_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		f_status.open |-> (f_status.left != 8'd0))
		else $error("open packet with no bytes left");

	a_drop_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == crcpf_pkg::MODE_PAYLOAD
		&& !f_status.open) |-> !q_push)
		else $error("payload without open packet was queued");

endmodule
